// File: sv/ncp_pkg.sv
// Package for the nucleotide 2-bit chunk packer: widths, result kinds and the
// bundle type that travels from the front end to the back end.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ncp_pkg;

    localparam int MaxChunk = 65536;
    localparam int PosW     = $clog2(MaxChunk + 1);
    localparam int CodeW    = 8;
    localparam int WordW    = 32;
    localparam int OffW     = 48;
    localparam int LenW     = 17;
    localparam int KindW    = 2;

    localparam int QDepth   = 4;
    localparam int QPtrW    = $clog2(QDepth);
    localparam int QCntW    = $clog2(QDepth + 1);

    localparam logic [KindW-1:0] KIND_PACKED = 2'd0;
    localparam logic [KindW-1:0] KIND_MASK   = 2'd1;
    localparam logic [KindW-1:0] KIND_RECORD = 2'd2;

    // All results caused by one residue
    typedef struct packed {
        logic             pk_v;
        logic [WordW-1:0] pk_word;
        logic [OffW-1:0]  pk_off;
        logic             mk_v;
        logic [WordW-1:0] mk_word;
        logic [OffW-1:0]  mk_off;
        logic             rec_v;
        logic [OffW-1:0]  rec_pstart;
        logic [OffW-1:0]  rec_mstart;
        logic [LenW-1:0]  rec_len;
    } bundle_t;

    typedef struct packed {
        logic    valid;
        bundle_t data;
    } q_push_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

`default_nettype wire

// File: sv/ncp_if.sv
// Channel interfaces of the packer: residue input and result output.
// Depends on ncp_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface ncp_in_if
    import ncp_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [CodeW-1:0] residue_code;
    logic             last_in_chunk;

    modport source (output valid, output residue_code, output last_in_chunk, input ready);
    modport sink   (input valid, input residue_code, input last_in_chunk, output ready);
endinterface

interface ncp_out_if
    import ncp_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [KindW-1:0] kind;
    logic [WordW-1:0] word;
    logic [OffW-1:0]  byte_offset;
    logic [OffW-1:0]  mask_start;
    logic [LenW-1:0]  chunk_length;
    logic             last_of_item;

    modport source (output valid, output kind, output word, output byte_offset,
                    output mask_start, output chunk_length, output last_of_item,
                    input ready);
    modport sink   (input valid, input kind, input word, input byte_offset,
                    input mask_start, input chunk_length, input last_of_item,
                    output ready);
endinterface

`default_nettype wire

// File: sv/nucleotide_2bit_chunk_packer.sv
// Top level of the nucleotide 2-bit chunk packer.
// Depends on ncp_pkg, ncp_if, ncp_front, ncp_queue, ncp_back.
`timescale 1ns / 1ps
`default_nettype none

// One residue is accepted per cycle while the queue is not full. Each residue
// packs into a 32-bit packed word (16 residues) and a 32-bit mask word (32
// residues, set for non-ACGT codes); full words, and at a chunk's end the padded
// words plus a chunk record, are queued as one bundle in a 4-entry queue and
// sent out one result per cycle while the output is ready. Results of an
// accepted residue are registered in the queue before they reach the output.
// Throughput is bounded by the single output port: long chunks run at one
// residue per cycle when the output does not stall, and one-residue chunks emit
// three results each; the input stalls only while the queue holds four pending
// bundles.
// Chunks longer than 65536 residues are closed at 65536.
module nucleotide_2bit_chunk_packer
    import ncp_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    ncp_in_if.sink    residue,
    ncp_out_if.source result
);

    q_push_t   push;
    q_status_t qstat;
    bundle_t   head;
    logic      pop;

    ncp_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .residue (residue),
        .qstat   (qstat),
        .push    (push)
    );

    ncp_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (pop),
        .head  (head),
        .qstat (qstat)
    );

    ncp_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head),
        .qstat  (qstat),
        .pop    (pop),
        .result (result)
    );

    a_last_pushes: assert property (@(posedge clk) disable iff (!rst_n)
        residue.valid && residue.ready && residue.last_in_chunk |-> push.valid)
        else $error("chunk end accepted without a queued bundle");

    a_record_final: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && (result.kind == KIND_RECORD) |-> result.last_of_item)
        else $error("chunk record not marked as final result");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !qstat.empty)
        else $error("bundle queue popped while empty");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        push.valid |-> !qstat.full)
        else $error("bundle pushed into full queue");

endmodule

`default_nettype wire

// File: sv/ncp_front.sv
// Front end: accepts residues, packs them into the accumulators, keeps the
// region offsets and pushes a bundle of due results. Depends on ncp_pkg, ncp_if.
`timescale 1ns / 1ps
`default_nettype none

module ncp_front
    import ncp_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    ncp_in_if.sink     residue,
    input  q_status_t  qstat,
    output q_push_t    push
);

    logic [WordW-1:0] pacc_reg, pacc_next;
    logic [WordW-1:0] macc_reg, macc_next;
    logic [PosW-1:0]  pos_reg, pos_next;
    logic [OffW-1:0]  poff_reg, poff_next;
    logic [OffW-1:0]  moff_reg, moff_next;
    logic [OffW-1:0]  pstart_reg, pstart_next;
    logic [OffW-1:0]  mstart_reg, mstart_next;

    logic             accept;
    logic             is_base;
    logic [PosW-1:0]  count;
    logic             last;
    logic             pk_emit;
    logic             mk_emit;
    logic [WordW-1:0] pk_word;
    logic [WordW-1:0] mk_word;

    assign residue.ready = !qstat.full;
    assign accept        = residue.valid && residue.ready;
    assign is_base       = (residue.residue_code[CodeW-1:2] == '0);
    assign count         = pos_reg + 1'b1;
    assign last          = residue.last_in_chunk || (count >= PosW'(MaxChunk));
    assign pk_emit       = (count[3:0] == 4'd0) || last;
    assign mk_emit       = (count[4:0] == 5'd0) || last;

    always_comb
    begin
        pk_word = pacc_reg;
        mk_word = macc_reg;
        if (is_base)
        begin
            pk_word = pacc_reg | (WordW'(residue.residue_code[1:0]) << {pos_reg[3:0], 1'b0});
        end
        else
        begin
            mk_word = macc_reg | (WordW'(1) << pos_reg[4:0]);
        end
    end

    always_comb
    begin
        pacc_next   = pacc_reg;
        macc_next   = macc_reg;
        pos_next    = pos_reg;
        poff_next   = poff_reg;
        moff_next   = moff_reg;
        pstart_next = pstart_reg;
        mstart_next = mstart_reg;

        push.valid           = accept && (pk_emit || mk_emit);
        push.data.pk_v       = pk_emit;
        push.data.pk_word    = pk_word;
        push.data.pk_off     = poff_reg;
        push.data.mk_v       = mk_emit;
        push.data.mk_word    = mk_word;
        push.data.mk_off     = moff_reg;
        push.data.rec_v      = last;
        push.data.rec_pstart = pstart_reg;
        push.data.rec_mstart = mstart_reg;
        push.data.rec_len    = LenW'(count);

        if (accept)
        begin
            pacc_next = pk_emit ? '0 : pk_word;
            macc_next = mk_emit ? '0 : mk_word;
            if (pk_emit)
            begin
                poff_next = poff_reg + OffW'(4);
            end
            if (mk_emit)
            begin
                moff_next = moff_reg + OffW'(4);
            end
            if (last)
            begin
                // next chunk opens where this one's padded words end
                pstart_next = poff_next;
                mstart_next = moff_next;
                pos_next    = '0;
            end
            else
            begin
                pos_next = count;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pacc_reg   <= '0;
            macc_reg   <= '0;
            pos_reg    <= '0;
            poff_reg   <= '0;
            moff_reg   <= '0;
            pstart_reg <= '0;
            mstart_reg <= '0;
        end
        else
        begin
            pacc_reg   <= pacc_next;
            macc_reg   <= macc_next;
            pos_reg    <= pos_next;
            poff_reg   <= poff_next;
            moff_reg   <= moff_next;
            pstart_reg <= pstart_next;
            mstart_reg <= mstart_next;
        end
    end

endmodule

`default_nettype wire

// File: sv/ncp_queue.sv
// Short bundle queue between front end and back end.
// Depends on ncp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ncp_queue
    import ncp_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  q_push_t    push,
    input  wire logic  pop,
    output bundle_t    head,
    output q_status_t  qstat
);

    bundle_t          mem [QDepth];
    logic [QPtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCntW-1:0] cnt_reg, cnt_next;
    logic             do_push;
    logic             do_pop;

    assign qstat.full  = (cnt_reg == QCntW'(QDepth));
    assign qstat.empty = (cnt_reg == '0);
    assign do_push     = push.valid && !qstat.full;
    assign do_pop      = pop && !qstat.empty;
    assign head        = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

`default_nettype wire

// File: sv/ncp_back.sv
// Back end: walks the head bundle and presents its packed word, mask word and
// chunk record, those set, one word per cycle when ready. Depends on ncp_pkg, ncp_if.
`timescale 1ns / 1ps
`default_nettype none

module ncp_back
    import ncp_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  bundle_t    head,
    input  q_status_t  qstat,
    output logic       pop,
    ncp_out_if.source  result
);

    logic pk_done_reg, pk_done_next;
    logic mk_done_reg, mk_done_next;
    logic sel_pk;
    logic sel_mk;
    logic final_word;
    logic taken;

    assign sel_pk = head.pk_v && !pk_done_reg;
    assign sel_mk = !sel_pk && head.mk_v && !mk_done_reg;
    assign taken  = result.valid && result.ready;

    always_comb
    begin
        if (sel_pk)
        begin
            final_word = !(head.mk_v || head.rec_v);
        end
        else if (sel_mk)
        begin
            final_word = !head.rec_v;
        end
        else
        begin
            final_word = 1'b1;
        end
    end

    always_comb
    begin
        result.valid        = !qstat.empty;
        result.last_of_item = final_word;
        result.kind         = KIND_RECORD;
        result.word         = '0;
        result.byte_offset  = head.rec_pstart;
        result.mask_start   = head.rec_mstart;
        result.chunk_length = head.rec_len;
        if (sel_pk)
        begin
            result.kind         = KIND_PACKED;
            result.word         = head.pk_word;
            result.byte_offset  = head.pk_off;
            result.mask_start   = '0;
            result.chunk_length = '0;
        end
        else if (sel_mk)
        begin
            result.kind         = KIND_MASK;
            result.word         = head.mk_word;
            result.byte_offset  = head.mk_off;
            result.mask_start   = '0;
            result.chunk_length = '0;
        end
    end

    always_comb
    begin
        pop          = taken && final_word;
        pk_done_next = pk_done_reg;
        mk_done_next = mk_done_reg;
        if (taken)
        begin
            if (final_word)
            begin
                pk_done_next = 1'b0;
                mk_done_next = 1'b0;
            end
            else if (sel_pk)
            begin
                pk_done_next = 1'b1;
            end
            else
            begin
                mk_done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pk_done_reg <= 1'b0;
            mk_done_reg <= 1'b0;
        end
        else
        begin
            pk_done_reg <= pk_done_next;
            mk_done_reg <= mk_done_next;
        end
    end

endmodule

`default_nettype wire

// File: dv/ncp_result_check.sv
// Result checker for the nucleotide 2-bit chunk packer: watches both channels,
// predicts the words and chunk records of every accepted residue and compares.
// Depends on ncp_pkg and the channel interfaces in ncp_if.
`timescale 1ns / 1ps

module ncp_result_check
    import ncp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    ncp_in_if    in_ch,
    ncp_out_if   out_ch,
    output int   errors,
    output int   outstanding,
    output int   checked
);

    typedef struct packed {
        logic [KindW-1:0] kind;
        logic [WordW-1:0] word;
        logic [OffW-1:0]  byte_offset;
        logic [OffW-1:0]  mask_start;
        logic [LenW-1:0]  chunk_length;
        logic             last_of_item;
    } packer_result_t;

    packer_result_t   due_results[$];

    logic [WordW-1:0] packed_acc;
    logic [WordW-1:0] mask_acc;
    logic [LenW-1:0]  chunk_pos;
    logic [OffW-1:0]  packed_off;
    logic [OffW-1:0]  mask_byte_off;
    logic [OffW-1:0]  chunk_packed_start;
    logic [OffW-1:0]  chunk_mask_start;

    initial
    begin
        errors      = 0;
        outstanding = 0;
        checked     = 0;
    end

    task automatic report_mismatch(input string msg);
        errors++;
        // keep the log bounded on a badly broken block
        if (errors <= 40)
            $display("[%0t] MISMATCH %s", $time, msg);
    endtask

    // Pack one residue and queue every word and record it closes.
    task automatic pack_residue(input logic [CodeW-1:0] code, input logic last_mark);
        packer_result_t found [3];
        packer_result_t r;
        logic [LenW-1:0] count;
        logic            closing;
        int              n;
        n = 0;
        closing = last_mark;
        if (code <= 8'd3)
            packed_acc |= {30'b0, code[1:0]} << {chunk_pos[3:0], 1'b0};
        else
            mask_acc |= 32'd1 << chunk_pos[4:0];
        count = chunk_pos + 1'b1;
        // force the chunk closed at the length limit
        if (count >= MaxChunk)
            closing = 1'b1;
        if (count[3:0] == 4'd0 || closing)
        begin
            r = '0;
            r.kind = KIND_PACKED;
            r.word = packed_acc;
            r.byte_offset = packed_off;
            found[n] = r;
            n++;
            packed_acc = '0;
            packed_off = packed_off + 48'd4;
        end
        if (count[4:0] == 5'd0 || closing)
        begin
            r = '0;
            r.kind = KIND_MASK;
            r.word = mask_acc;
            r.byte_offset = mask_byte_off;
            found[n] = r;
            n++;
            mask_acc = '0;
            mask_byte_off = mask_byte_off + 48'd4;
        end
        if (closing)
        begin
            r = '0;
            r.kind = KIND_RECORD;
            r.byte_offset = chunk_packed_start;
            r.mask_start = chunk_mask_start;
            r.chunk_length = count;
            found[n] = r;
            n++;
            chunk_packed_start = packed_off;
            chunk_mask_start = mask_byte_off;
            chunk_pos = '0;
        end
        else
            chunk_pos = count;
        if (n > 0)
            found[n-1].last_of_item = 1'b1;
        for (int i = 0; i < n; i++)
            due_results.push_back(found[i]);
    endtask

    task automatic compare_result(input packer_result_t got);
        packer_result_t want;
        if (due_results.size() == 0)
        begin
            report_mismatch($sformatf("unexpected result kind %0d word %h", got.kind, got.word));
            return;
        end
        want = due_results.pop_front();
        checked++;
        if (got.kind !== want.kind)
            report_mismatch($sformatf("kind: got %0d want %0d", got.kind, want.kind));
        if (got.word !== want.word)
            report_mismatch($sformatf("word: got %h want %h", got.word, want.word));
        if (got.byte_offset !== want.byte_offset)
            report_mismatch($sformatf("byte_offset: got %h want %h",
                                      got.byte_offset, want.byte_offset));
        if (got.mask_start !== want.mask_start)
            report_mismatch($sformatf("mask_start: got %h want %h",
                                      got.mask_start, want.mask_start));
        if (got.chunk_length !== want.chunk_length)
            report_mismatch($sformatf("chunk_length: got %0d want %0d",
                                      got.chunk_length, want.chunk_length));
        if (got.last_of_item !== want.last_of_item)
            report_mismatch($sformatf("last_of_item: got %b want %b",
                                      got.last_of_item, want.last_of_item));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            due_results.delete();
            packed_acc         = '0;
            mask_acc           = '0;
            chunk_pos          = '0;
            packed_off         = '0;
            mask_byte_off      = '0;
            chunk_packed_start = '0;
            chunk_mask_start   = '0;
            outstanding        = 0;
        end
        else
        begin
            // compare first, so a result never matches a residue taken on the same edge
            if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
                compare_result('{out_ch.kind, out_ch.word, out_ch.byte_offset,
                                 out_ch.mask_start, out_ch.chunk_length,
                                 out_ch.last_of_item});
            if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1)
                pack_residue(in_ch.residue_code, in_ch.last_in_chunk);
            outstanding = due_results.size();
        end
    end

endmodule

// File: dv/tb_nucleotide_2bit_chunk_packer.sv
// Testbench top for the nucleotide 2-bit chunk packer: drives residue chunks
// with random gaps and output stalls, and gives the verdict.
// Depends on ncp_pkg, ncp_if, the packer RTL and ncp_result_check.
`timescale 1ns / 1ps

module tb_nucleotide_2bit_chunk_packer;
    import ncp_pkg::*;

    logic clk;
    logic rst_n;

    int   errors;
    int   outstanding;
    int   checked;

    int   residues_sent;
    int   chunks_sent;
    int   gap_cap;
    int   stall_cap;
    bit   no_gaps;

    ncp_in_if  res_in ();
    ncp_out_if res_out ();

    nucleotide_2bit_chunk_packer u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .residue(res_in),
        .result (res_out)
    );

    ncp_result_check u_result_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (res_in),
        .out_ch     (res_out),
        .errors     (errors),
        .outstanding(outstanding),
        .checked    (checked)
    );

    initial
        clk = 1'b0;

    always #6 clk = ~clk;

    // Mostly no gap, some short ones, a few up to the cap.
    function automatic int pick_gap(input int cap);
        int r;
        if (cap <= 0)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, (cap < 3) ? cap : 3);
        return $urandom_range(0, cap);
    endfunction

    // Random output stalls; the pattern runs on its own for the whole test.
    initial
    begin
        int n_on;
        int n_off;
        res_out.ready = 1'b0;
        forever
        begin
            n_on = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 12);
            repeat (n_on) @(negedge clk) res_out.ready <= 1'b1;
            n_off = pick_gap(stall_cap);
            repeat (n_off) @(negedge clk) res_out.ready <= 1'b0;
        end
    end

    task automatic push_residue(input logic [CodeW-1:0] code, input logic last_mark);
        int gap;
        gap = no_gaps ? 0 : pick_gap(gap_cap);
        repeat (gap)
        begin
            @(negedge clk);
            res_in.valid        <= 1'b0;
            res_in.residue_code <= CodeW'($urandom);
        end
        @(negedge clk);
        res_in.valid         <= 1'b1;
        res_in.residue_code  <= code;
        res_in.last_in_chunk <= last_mark;
        do
            @(posedge clk);
        while (res_in.ready !== 1'b1);
        residues_sent++;
        if (last_mark)
            chunks_sent++;
    endtask

    function automatic logic [CodeW-1:0] pick_code();
        if ($urandom_range(0, 3) != 0)
            return CodeW'($urandom_range(0, 3));
        return CodeW'($urandom_range(0, 255));
    endfunction

    task automatic push_chunk(input int len);
        no_gaps = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < len; i++)
            push_residue(pick_code(), i == len - 1);
    endtask

    initial
    begin
        logic [CodeW-1:0] edge_codes [16];
        int len;
        int r;

        edge_codes = '{8'd3, 8'd2, 8'd1, 8'd0, 8'd4, 8'd8, 8'd16,
                       8'd32, 8'd64, 8'd128, 8'd3, 8'd3, 8'd0,
                       8'd1, 8'd2, 8'd3};
        rst_n                = 1'b0;
        res_in.valid         = 1'b0;
        res_in.residue_code  = '0;
        res_in.last_in_chunk = 1'b0;
        residues_sent        = 0;
        chunks_sent          = 0;
        gap_cap              = 25;
        stall_cap            = 25;
        no_gaps              = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;

        // Directed: one-residue chunks of a base and of the top code
        push_residue(8'd0, 1'b1);
        push_residue(8'd255, 1'b1);
        // full packed word that also ends the chunk, every code bit set somewhere
        for (int i = 0; i < 16; i++)
            push_residue(edge_codes[i], i == 15);
        push_residue(8'd1, 1'b0);
        push_residue(8'd127, 1'b0);
        push_residue(8'd2, 1'b1);

        // Random chunks, mostly short, some past several word boundaries
        while (residues_sent < 200)
        begin
            r = $urandom_range(0, 99);
            if (r < 10)
                len = 1;
            else if (r < 70)
                len = $urandom_range(1, 40);
            else
                len = $urandom_range(41, 100);
            push_chunk(len);
        end

        push_chunk($urandom_range(1, 40));
        push_chunk($urandom_range(1, 40));

        @(negedge clk) res_in.valid <= 1'b0;
        wait (outstanding == 0);
        repeat (50) @(posedge clk);

        $display("Sent %0d residues in %0d chunks under random input gaps and output stalls;",
                 residues_sent, chunks_sent);
        $display("checked %0d packed words, mask words and chunk records.", checked);
        if (errors == 0 && outstanding == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("Timeout waiting for results");
        $display("Mismatches found");
        $finish;
    end

endmodule

// File: files.f
sv/ncp_pkg.sv
sv/ncp_if.sv
sv/ncp_front.sv
sv/ncp_queue.sv
sv/ncp_back.sv
sv/nucleotide_2bit_chunk_packer.sv
dv/ncp_result_check.sv
dv/tb_nucleotide_2bit_chunk_packer.sv
